FILE: design/polygon_area_centroid_top_assert.svh
// Assertion macros used by the polygon area and centroid controller
`ifndef POLYGON_AREA_CENTROID_TOP_ASSERT_SVH
`define POLYGON_AREA_CENTROID_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pac_pkg.sv
// Shared widths, constants and control structs for the polygon area and centroid block
package pac_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_VERTICES   = 65535;

  localparam int AREA_W      = 27;
  localparam int MOM_W       = 42;
  localparam int SUM_W       = 28;
  localparam int CNT_W       = 16;
  localparam int BLOB_AREA_W = 25;
  localparam int CENTRE_W    = 20;
  localparam int FRAC_BITS   = 8;

  localparam int NUM_W = MOM_W + FRAC_BITS;
  localparam int DEN_W = AREA_W + 1;

  localparam logic [BLOB_AREA_W-1:0] MIN_AREA_RST = BLOB_AREA_W'(100);

  typedef struct packed {
    logic accept;
    logic close;
    logic start_div;
    logic sel_y;
    logic load_x;
    logic load_out;
    logic clear;
  } pac_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } pac_status_t;

  typedef struct packed {
    logic             start;
    logic             force_zero;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } pac_div_req_t;

endpackage

FILE: design/polygon_area_centroid_top.sv
// Top level of the shoelace polygon area and centroid block
//
//   port group   direction  handshake        payload
//   in_*         input      valid / stall    vx, vy, final_vertex (one boundary vertex)
//   out_*        output     valid / stall    blob_area, center_x, center_y, large_blob
//   cfg_*        input      valid / ready    min_area
//
// Vertices are taken one per cycle while in_stall is low; the accumulators sit behind a
// three-stage edge pipeline. After the final vertex in_stall stays high through close, drain,
// the divisions and hand-off; the shared restoring divider runs once per centroid axis.
// The result sits in an output register; a stalled result holds the block only at hand-off.
// rst_n is synchronous; it clears the sums and sets min_area to 100. cfg_ready is always high.
module polygon_area_centroid_top
  import pac_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_BITS-1:0]  in_vx,
  input  logic [COORD_BITS-1:0]  in_vy,
  input  logic                   in_final_vertex,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BLOB_AREA_W-1:0] out_blob_area,
  output logic [CENTRE_W-1:0]    out_center_x,
  output logic [CENTRE_W-1:0]    out_center_y,
  output logic                   out_large_blob,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [BLOB_AREA_W-1:0] cfg_min_area
);

  pac_cmd_t            cmd;
  pac_status_t         st;
  pac_div_req_t        div_req;
  logic                div_done;
  logic [CENTRE_W-1:0] div_quot;
  logic                cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  pac_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_final_vertex (in_final_vertex),
    .in_stall        (in_stall),
    .out_stall       (out_stall),
    .st              (st),
    .div_done        (div_done),
    .cmd             (cmd)
  );

  pac_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vx           (in_vx),
    .in_vy           (in_vy),
    .in_final_vertex (in_final_vertex),
    .cfg_wr          (cfg_wr),
    .cfg_min_area    (cfg_min_area),
    .cmd             (cmd),
    .st              (st),
    .div_req         (div_req),
    .div_quot        (div_quot),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_blob_area   (out_blob_area),
    .out_center_x    (out_center_x),
    .out_center_y    (out_center_y),
    .out_large_blob  (out_large_blob)
  );

  pac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

FILE: design/pac_div.sv
// Restoring divider with saturation and forced zero, one quotient bit per cycle
module pac_div
  import pac_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  pac_div_req_t        req,
  output logic                done,
  output logic [CENTRE_W-1:0] quot
);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_RUN   = 2'd2;

  localparam int HI_W  = NUM_W - CENTRE_W;
  localparam int CNT_DW = $clog2(CENTRE_W);

  logic [1:0]          state_r, state_nxt;
  logic                done_r, done_nxt;
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;
  logic                zero_r;
  logic [DEN_W-1:0]    rem_r;
  logic [CENTRE_W-1:0] lo_r;
  logic [CNT_DW-1:0]   cnt_r;

  logic [HI_W-1:0]  hi;
  logic             sat;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign hi    = num_r[NUM_W-1:CENTRE_W];
  assign sat   = hi >= HI_W'(den_r);
  assign trial = {rem_r, lo_r[CENTRE_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (req.start) state_nxt = D_CHECK;
      end
      D_CHECK: begin
        if (zero_r || sat) begin
          state_nxt = D_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = D_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          num_r  <= req.num;
          den_r  <= req.den;
          zero_r <= req.force_zero;
        end
      end
      D_CHECK: begin
        // opposite signs give zero; a quotient past the field clamps to all ones
        if (zero_r) begin
          lo_r <= '0;
        end else if (sat) begin
          lo_r <= '1;
        end else begin
          rem_r <= hi[DEN_W-1:0];
          lo_r  <= num_r[CENTRE_W-1:0];
          cnt_r <= CNT_DW'(CENTRE_W - 1);
        end
      end
      D_RUN: begin
        rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_r  <= {lo_r[CENTRE_W-2:0], ge};
        cnt_r <= cnt_r - CNT_DW'(1);
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign quot = lo_r;

endmodule

FILE: design/pac_dp.sv
// Datapath: vertex capture, shoelace edge pipeline, accumulators, divider operands, result register
module pac_dp
  import pac_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COORD_BITS-1:0]  in_vx,
  input  logic [COORD_BITS-1:0]  in_vy,
  input  logic                   in_final_vertex,
  input  logic                   cfg_wr,
  input  logic [BLOB_AREA_W-1:0] cfg_min_area,
  input  pac_cmd_t               cmd,
  output pac_status_t            st,
  output pac_div_req_t           div_req,
  input  logic [CENTRE_W-1:0]    div_quot,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [BLOB_AREA_W-1:0] out_blob_area,
  output logic [CENTRE_W-1:0]    out_center_x,
  output logic [CENTRE_W-1:0]    out_center_y,
  output logic                   out_large_blob
);

  localparam int PT_W   = 2 * COORD_BITS;
  localparam int CR_W   = 2 * COORD_BITS + 1;
  localparam int SS_W   = COORD_BITS + 1;
  localparam int PROD_W = CR_W + SS_W + 1;

  localparam logic [CNT_W:0]         MAXV     = (CNT_W + 1)'(MAX_VERTICES);
  localparam logic [BLOB_AREA_W-1:0] AREA_MAX = '1;

  logic [PT_W-1:0]        first_r, prev_r;
  logic                   e_v_r, a_v_r, b_v_r;
  logic [PT_W-1:0]        e_p_r, e_q_r;
  logic signed [CR_W-1:0] cr_r;
  logic [SS_W-1:0]        sx_r, sy_r;
  logic [MOM_W-1:0]       mx_r, my_r;
  logic [AREA_W-1:0]      twice_r;
  logic [MOM_W-1:0]       momx_r, momy_r;
  logic [SUM_W-1:0]       sumx_r, sumy_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BLOB_AREA_W-1:0] min_area_r;
  logic [CENTRE_W-1:0]    qx_r;
  logic                   out_valid_r;
  logic [BLOB_AREA_W-1:0] area_r;
  logic [CENTRE_W-1:0]    cx_r, cy_r;
  logic                   large_r;

  logic [PT_W-1:0]          pt;
  logic                     drop, take;
  logic [COORD_BITS-1:0]    x1, y1, x2, y2;
  logic [PT_W-1:0]          pa, pb;
  logic signed [CR_W-1:0]   cr_nxt;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic                     tneg, mneg, tzero;
  logic [AREA_W-1:0]        tmag, area_full;
  logic [MOM_W-1:0]         mom, mmag;
  logic [SUM_W-1:0]         sum;
  logic [BLOB_AREA_W-1:0]   area_sat;

  assign pt   = {in_vy, in_vx};
  // keep one slot free for the final vertex
  assign drop = !in_final_vertex && ((CNT_W + 1)'(cnt_r) + (CNT_W + 1)'(1) >= MAXV);
  assign take = cmd.accept && !drop;

  // edge stage: cross product and end-coordinate sums
  assign x1     = e_p_r[COORD_BITS-1:0];
  assign y1     = e_p_r[PT_W-1:COORD_BITS];
  assign x2     = e_q_r[COORD_BITS-1:0];
  assign y2     = e_q_r[PT_W-1:COORD_BITS];
  assign pa     = PT_W'(x1) * PT_W'(y2);
  assign pb     = PT_W'(x2) * PT_W'(y1);
  assign cr_nxt = $signed({1'b0, pa}) - $signed({1'b0, pb});

  assign prod_x = PROD_W'(cr_r) * PROD_W'($signed({1'b0, sx_r}));
  assign prod_y = PROD_W'(cr_r) * PROD_W'($signed({1'b0, sy_r}));

  // divider operands and area from the finished sums
  assign tneg      = twice_r[AREA_W-1];
  assign tmag      = tneg ? (~twice_r + AREA_W'(1)) : twice_r;
  assign tzero     = twice_r == '0;
  assign mom       = cmd.sel_y ? momy_r : momx_r;
  assign mneg      = mom[MOM_W-1];
  assign mmag      = mneg ? (~mom + MOM_W'(1)) : mom;
  assign sum       = cmd.sel_y ? sumy_r : sumx_r;
  assign area_full = tmag >> 1;
  assign area_sat  = (area_full > AREA_W'(AREA_MAX)) ? AREA_MAX
                                                      : area_full[BLOB_AREA_W-1:0];

  always_comb begin
    div_req.start      = cmd.start_div;
    div_req.force_zero = !tzero && (mneg != tneg);
    if (tzero) begin
      div_req.num = NUM_W'({sum, {FRAC_BITS{1'b0}}});
      div_req.den = DEN_W'(cnt_r);
    end else begin
      div_req.num = {mmag, {FRAC_BITS{1'b0}}};
      div_req.den = {1'b0, tmag} + {tmag, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      prev_r      <= '0;
      twice_r     <= '0;
      momx_r      <= '0;
      momy_r      <= '0;
      sumx_r      <= '0;
      sumy_r      <= '0;
      cnt_r       <= '0;
      e_v_r       <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      min_area_r  <= MIN_AREA_RST;
    end else begin
      if (cfg_wr) min_area_r <= cfg_min_area;
      if (cmd.clear) begin
        first_r <= '0;
        prev_r  <= '0;
        twice_r <= '0;
        momx_r  <= '0;
        momy_r  <= '0;
        sumx_r  <= '0;
        sumy_r  <= '0;
        cnt_r   <= '0;
      end else begin
        if (take) begin
          if (cnt_r == '0) first_r <= pt;
          prev_r <= pt;
          sumx_r <= sumx_r + SUM_W'(in_vx);
          sumy_r <= sumy_r + SUM_W'(in_vy);
          cnt_r  <= cnt_r + CNT_W'(1);
        end
        if (a_v_r) twice_r <= twice_r + AREA_W'(cr_r);
        if (b_v_r) begin
          momx_r <= momx_r + mx_r;
          momy_r <= momy_r + my_r;
        end
      end
      e_v_r <= (take && cnt_r != '0) || cmd.close;
      a_v_r <= e_v_r;
      b_v_r <= a_v_r;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // closing edge runs from the last vertex back to the first
    e_p_r <= prev_r;
    e_q_r <= cmd.close ? first_r : pt;
    cr_r  <= cr_nxt;
    sx_r  <= SS_W'(x1) + SS_W'(x2);
    sy_r  <= SS_W'(y1) + SS_W'(y2);
    mx_r  <= MOM_W'(prod_x);
    my_r  <= MOM_W'(prod_y);
    if (cmd.load_x) qx_r <= div_quot;
    if (cmd.load_out) begin
      area_r  <= area_sat;
      cx_r    <= qx_r;
      cy_r    <= div_quot;
      large_r <= area_sat >= min_area_r;
    end
  end

  assign st.pipe_busy = e_v_r || a_v_r || b_v_r;
  assign st.out_full  = out_valid_r;

  assign out_valid      = out_valid_r;
  assign out_blob_area  = area_r;
  assign out_center_x   = cx_r;
  assign out_center_y   = cy_r;
  assign out_large_blob = large_r;

endmodule

FILE: design/pac_ctrl.sv
// Controller: sequences vertex intake, polygon close, pipeline drain, divisions and result hand-off
`include "polygon_area_centroid_top_assert.svh"

module pac_ctrl
  import pac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_final_vertex,
  output logic        in_stall,
  input  logic        out_stall,
  input  pac_status_t st,
  input  logic        div_done,
  output pac_cmd_t    cmd
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIVX  = 3'd3;
  localparam logic [2:0] S_DIVY  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       in_acc;

  assign in_stall = state_r != S_ACC;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_ACC: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_final_vertex) state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // wait for the closing edge to reach the moment sums
        if (!st.pipe_busy) begin
          cmd.start_div = 1'b1;
          state_nxt     = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          cmd.load_x    = 1'b1;
          cmd.start_div = 1'b1;
          cmd.sel_y     = 1'b1;
          state_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register has room
        if (!st.out_full || !out_stall) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PAC_ASSERT_NEXT(a_final_closes, in_acc && in_final_vertex, state_r == S_CLOSE, "final vertex did not close polygon")
  `PAC_ASSERT_NOW(a_load_has_room, cmd.load_out, !(st.out_full && out_stall), "result overwritten while stalled")
  `PAC_ASSERT_NOW(a_done_in_div, div_done, state_r == S_DIVX || state_r == S_DIVY, "divider finished outside a division state")

endmodule

FILE: dv/tb_polygon_area_centroid_top.sv
`timescale 1ns / 100ps
// Polygon area and centroid testbench: directed and random blobs checked by predictor or typed values
module tb_polygon_area_centroid_top;
  import pac_pkg::*;

  localparam int     CB            = COORD_BITS_DEF;
  localparam int     COORD_TOP     = (1 << CB) - 1;
  localparam int     GAP_MAX       = 13;
  localparam int     QUIET_LIMIT   = 2000;
  localparam int     SETTLE_CYC    = 64;
  localparam int     DIR_N         = 26;
  localparam longint AREA_MAX      = (64'd1 << BLOB_AREA_W) - 1;
  localparam longint CENTRE_MAX    = (64'd1 << CENTRE_W) - 1;
  localparam logic [BLOB_AREA_W-1:0] MIN_AREA_TOP = '1;
  localparam logic [BLOB_AREA_W-1:0] MIN_AREA_MID = BLOB_AREA_W'(1 << 24);

  typedef struct packed {
    logic [BLOB_AREA_W-1:0] area;
    logic [CENTRE_W-1:0]    cx;
    logic [CENTRE_W-1:0]    cy;
    logic                   big;
  } blob_result_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
    logic          fixed;
    blob_result_t  res;
  } stim_row_t;

  // single vertices, full-frame square, collinear run, bow-tie with opposite moment,
  // square wound past the area sum width
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{12'd0,    12'd0,    1'b1, 1'b1, '{25'd0, 20'd0, 20'd0, 1'b0}},
    '{12'd4095, 12'd4095, 1'b1, 1'b1, '{25'd0, 20'd1048320, 20'd1048320, 1'b0}},
    '{12'd0,    12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, '0},
    '{12'd0,    12'd4095, 1'b1, 1'b1, '{25'd16769025, 20'd524160, 20'd524160, 1'b1}},
    '{12'd0,    12'd5,    1'b0, 1'b0, '0},
    '{12'd10,   12'd10,   1'b0, 1'b0, '0},
    '{12'd20,   12'd15,   1'b1, 1'b0, '0},
    '{12'd0,    12'd0,    1'b0, 1'b0, '0},
    '{12'd40,   12'd0,    1'b0, 1'b0, '0},
    '{12'd0,    12'd40,   1'b0, 1'b0, '0},
    '{12'd0,    12'd0,    1'b0, 1'b0, '0},
    '{12'd1000, 12'd1,    1'b0, 1'b0, '0},
    '{12'd1001, 12'd0,    1'b1, 1'b0, '0},
    '{12'd0,    12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, '0},
    '{12'd0,    12'd4095, 1'b0, 1'b0, '0},
    '{12'd0,    12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, '0},
    '{12'd0,    12'd4095, 1'b0, 1'b0, '0},
    '{12'd0,    12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd0,    1'b0, 1'b0, '0},
    '{12'd4095, 12'd4095, 1'b1, 1'b0, '0}
  };

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_stall;
  logic [CB-1:0]          in_vx           = '0;
  logic [CB-1:0]          in_vy           = '0;
  logic                   in_final_vertex = 1'b0;
  logic                   out_valid;
  logic                   out_stall       = 1'b0;
  logic [BLOB_AREA_W-1:0] out_blob_area;
  logic [CENTRE_W-1:0]    out_center_x;
  logic [CENTRE_W-1:0]    out_center_y;
  logic                   out_large_blob;
  logic                   cfg_valid       = 1'b0;
  logic                   cfg_ready;
  logic [BLOB_AREA_W-1:0] cfg_min_area    = '0;

  // typed-in expectation travelling with the request on the input channel
  logic                   row_fixed       = 1'b0;
  blob_result_t           row_fixed_res   = '0;

  bit                     sender_burst    = 1'b0;
  bit                     sink_burst      = 1'b0;
  blob_result_t           pending_blobs[$];
  int                     errors          = 0;
  int                     quiet_cycles    = 0;

  // predictor state
  logic [BLOB_AREA_W-1:0] large_threshold;
  logic [2*CB-1:0]        ring_first;
  logic [2*CB-1:0]        ring_prev;
  logic [AREA_W-1:0]      twice_area;
  logic [MOM_W-1:0]       moment_x;
  logic [MOM_W-1:0]       moment_y;
  logic [SUM_W-1:0]       sum_x;
  logic [SUM_W-1:0]       sum_y;
  logic [CNT_W-1:0]       vertex_total;

  polygon_area_centroid_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vx           (in_vx),
    .in_vy           (in_vy),
    .in_final_vertex (in_final_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_blob_area   (out_blob_area),
    .out_center_x    (out_center_x),
    .out_center_y    (out_center_y),
    .out_large_blob  (out_large_blob),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_min_area    (cfg_min_area)
  );

  always #10 clk = ~clk;

  function automatic void forget_blob();
    ring_first   = '0;
    ring_prev    = '0;
    twice_area   = '0;
    moment_x     = '0;
    moment_y     = '0;
    sum_x        = '0;
    sum_y        = '0;
    vertex_total = '0;
  endfunction

  function automatic void add_cross(input logic [2*CB-1:0] p, input logic [2*CB-1:0] q);
    longint x1, y1, x2, y2, cr;
    x1 = longint'(p[CB-1:0]);
    y1 = longint'(p[2*CB-1:CB]);
    x2 = longint'(q[CB-1:0]);
    y2 = longint'(q[2*CB-1:CB]);
    cr = x1 * y2 - x2 * y1;
    twice_area = twice_area + AREA_W'(cr);
    moment_x   = moment_x + MOM_W'(cr * (x1 + x2));
    moment_y   = moment_y + MOM_W'(cr * (y1 + y2));
  endfunction

  function automatic logic [CENTRE_W-1:0] centroid_axis(input logic signed [MOM_W-1:0] mom,
                                                        input logic signed [AREA_W-1:0] twice,
                                                        input logic [SUM_W-1:0] sum,
                                                        input logic [CNT_W-1:0] n);
    longint m, t, q;
    m = longint'(mom);
    t = longint'(twice);
    if (t != 0) begin
      // opposite signs give a centroid left of or above the frame: clamp to zero
      if (m == 0 || ((m < 0) != (t < 0))) return '0;
      if (m < 0) m = -m;
      if (t < 0) t = -t;
      q = (m << FRAC_BITS) / (3 * t);
    end else begin
      // no area: fall back to the vertex mean
      if (n == 0) return '0;
      q = (longint'(sum) << FRAC_BITS) / longint'(n);
    end
    return (q > CENTRE_MAX) ? '1 : CENTRE_W'(q);
  endfunction

  function automatic bit take_vertex(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                     input logic last, output blob_result_t r);
    logic [2*CB-1:0]          pt;
    logic signed [AREA_W-1:0] ts;
    longint                   t, a;
    pt = {y, x};
    r  = '0;
    // drop a non-final vertex once only the slot for the final one is left
    if (!last && int'(vertex_total) + 1 >= MAX_VERTICES) return 1'b0;
    if (vertex_total == 0) ring_first = pt;
    else add_cross(ring_prev, pt);
    ring_prev    = pt;
    sum_x        = sum_x + SUM_W'(x);
    sum_y        = sum_y + SUM_W'(y);
    vertex_total = vertex_total + CNT_W'(1);
    if (!last) return 1'b0;
    add_cross(pt, ring_first);
    ts = twice_area;
    t  = longint'(ts);
    a  = ((t < 0) ? -t : t) >> 1;
    if (a > AREA_MAX) a = AREA_MAX;
    r.area = BLOB_AREA_W'(a);
    r.cx   = centroid_axis(moment_x, twice_area, sum_x, vertex_total);
    r.cy   = centroid_axis(moment_y, twice_area, sum_y, vertex_total);
    r.big  = (r.area >= large_threshold);
    forget_blob();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    blob_result_t pred, want;
    bit           hit;
    if (!rst_n) begin
      forget_blob();
      large_threshold = MIN_AREA_RST;
      quiet_cycles    = 0;
    end else begin
      hit = 1'b0;
      if (cfg_valid && cfg_ready) begin
        large_threshold = cfg_min_area;
        hit = 1'b1;
      end
      if (in_valid && !in_stall) begin
        hit = 1'b1;
        if (take_vertex(in_vx, in_vy, in_final_vertex, pred))
          pending_blobs = {pending_blobs, (row_fixed ? row_fixed_res : pred)};
      end
      if (out_valid && !out_stall) begin
        hit = 1'b1;
        if (pending_blobs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result with no request pending: area %0d x %0d y %0d large %0d",
                     out_blob_area, out_center_x, out_center_y, out_large_blob);
        end else begin
          want = pending_blobs.pop_front();
          check_field("blob_area", 32'(want.area), 32'(out_blob_area));
          check_field("center_x", 32'(want.cx), 32'(out_center_x));
          check_field("center_y", 32'(want.cy), 32'(out_center_y));
          check_field("large_blob", 32'(want.big), 32'(out_large_blob));
        end
      end
      quiet_cycles = hit ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      hold = sink_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_vertex(input logic [CB-1:0] x, input logic [CB-1:0] y, input logic last,
                             input logic fixed = 1'b0, input blob_result_t res = '0);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_vx           <= x;
    in_vy           <= y;
    in_final_vertex <= last;
    row_fixed       <= fixed;
    row_fixed_res   <= res;
    // hold the request until taken
    do @(posedge clk); while (in_stall);
  endtask

  // walk the perimeter of a random box; corners alone give a rectangle
  task automatic send_ring(input int n, input int maxdim, input bit corners);
    int w, h, x0, y0, perim, p, px, py;
    int spots[$];
    bit flip;
    w     = $urandom_range(1, maxdim);
    h     = $urandom_range(1, maxdim);
    x0    = $urandom_range(0, COORD_TOP - w);
    y0    = $urandom_range(0, COORD_TOP - h);
    perim = 2 * (w + h);
    if (corners) begin
      spots = '{0, w, w + h, 2 * w + h};
    end else begin
      repeat (n) spots = {spots, int'($urandom_range(0, perim - 1))};
      spots.sort();
    end
    flip = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      p = flip ? spots[n - 1 - i] : spots[i];
      if (p < w) begin
        px = x0 + p;
        py = y0;
      end else if (p < w + h) begin
        px = x0 + w;
        py = y0 + p - w;
      end else if (p < 2 * w + h) begin
        px = x0 + w - (p - w - h);
        py = y0 + h;
      end else begin
        px = x0;
        py = y0 + h - (p - 2 * w - h);
      end
      send_vertex(CB'(px), CB'(py), i == n - 1);
    end
  endtask

  task automatic send_blob(output int count);
    int kind, x0, y0, dx, dy;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        count = 1;
        send_vertex(CB'($urandom), CB'($urandom), 1'b1);
      end
      1: begin
        count = 4;
        send_ring(4, COORD_TOP, 1'b1);
      end
      2, 3, 4, 5: begin
        count = $urandom_range(3, 10);
        send_ring(count, 200, 1'b0);
      end
      6, 7: begin
        // scattered points: self-crossing rings, wrapped sums
        count = $urandom_range(2, 12);
        for (int i = 0; i < count; i++)
          send_vertex(CB'($urandom), CB'($urandom), i == count - 1);
      end
      8: begin
        count = $urandom_range(2, 6);
        x0    = $urandom_range(0, 2000);
        y0    = $urandom_range(0, 2000);
        dx    = $urandom_range(0, 300);
        dy    = $urandom_range(0, 300);
        for (int i = 0; i < count; i++)
          send_vertex(CB'(x0 + i * dx), CB'(y0 + i * dy), i == count - 1);
      end
      default: begin
        count = $urandom_range(20, 40);
        send_ring(count, COORD_TOP, 1'b0);
      end
    endcase
  endtask

  task automatic random_blobs(input int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      sender_burst = ($urandom_range(0, 5) == 0);
      sink_burst   = sender_burst;
      send_blob(n);
      sent += n;
    end
    sender_burst = 1'b0;
    sink_burst   = 1'b0;
  endtask

  // drop valid, wait for every pending result, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_blobs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_min_area(input logic [BLOB_AREA_W-1:0] v);
    cfg_valid    <= 1'b1;
    cfg_min_area <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_vertex(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].last,
                  DIR_ROWS[i].fixed, DIR_ROWS[i].res);
    settle();

    write_min_area('0);
    random_blobs(250);
    settle();

    write_min_area(MIN_AREA_TOP);
    random_blobs(250);
    settle();

    write_min_area(BLOB_AREA_W'($urandom_range(50, 40000)));
    random_blobs(250);
    settle();

    write_min_area(MIN_AREA_MID);
    random_blobs(250);
    settle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
